### rtl/core/kac_pkg.sv
package kac_pkg;

  typedef logic [3:0] key_code_t;

  localparam key_code_t KEY_LAST_ENTRY = 4'd12;
  localparam key_code_t KEY_D          = 4'd13;
  localparam key_code_t KEY_STAR       = 4'd14;
  localparam key_code_t KEY_HASH       = 4'd15;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMING   = 2'd1,
    MODE_ARMED    = 2'd2,
    MODE_ALARM    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CHECK_NONE  = 2'd0,
    CHECK_OK    = 2'd1,
    CHECK_WRONG = 2'd2
  } check_t;

  // Bit positions in the LED level vector.
  localparam int LED_GREEN  = 0;
  localparam int LED_ORANGE = 1;
  localparam int LED_WHITE  = 2;

  typedef logic [2:0] led_t;

  localparam led_t LEDS_GREEN_ONLY  = 3'b001;
  localparam led_t LEDS_ORANGE_ONLY = 3'b010;
  localparam led_t LEDS_KEEP_GREEN  = 3'b001;
  localparam led_t LEDS_KEEP_WHITE  = 3'b100;

  typedef enum logic [1:0] {
    REG_PASSCODE_DIGITS = 2'd0,
    REG_PASSCODE_LENGTH = 2'd1,
    REG_ARMING_TICKS    = 2'd2,
    REG_BLINK_TICKS     = 2'd3
  } reg_index_t;

  localparam logic [31:0] PASSCODE_DIGITS_RESET = 32'h0314_1592;
  localparam logic [3:0]  PASSCODE_LENGTH_RESET = 4'd7;
  localparam logic [15:0] ARMING_TICKS_RESET    = 16'd5000;
  localparam logic [15:0] BLINK_TICKS_RESET     = 16'd500;

  // Outcome of a submit key, handed from the entry logic to the mode control.
  typedef struct packed {
    logic submit;
    logic match;
  } check_info_t;

endpackage

### rtl/core/kac_poll_if.sv
interface kac_poll_if;
  logic                valid;
  logic                ready;
  logic                key_valid;
  kac_pkg::key_code_t  key_code;
  logic                sound;
  logic                tick;

  modport source(output valid, key_valid, key_code, sound, tick, input ready);
  modport sink(input valid, key_valid, key_code, sound, tick, output ready);
endinterface

### rtl/core/kac_status_if.sv
interface kac_status_if;
  logic       valid;
  logic       ready;
  logic       lamp_green;
  logic       lamp_orange;
  logic       lamp_white;
  logic [1:0] mode;
  logic [3:0] entry_length;
  logic [1:0] check_result;

  modport source(output valid, lamp_green, lamp_orange, lamp_white, mode, entry_length,
                 check_result, input ready);
  modport sink(input valid, lamp_green, lamp_orange, lamp_white, mode, entry_length,
               check_result, output ready);
endinterface

### rtl/core/keypad_alarm_controller.sv
// Channel   Role    Payload
// poll      sink    key_valid, key_code, sound, tick
// status    source  lamp_green, lamp_orange, lamp_white, mode, entry_length, check_result
// cfg       write   cfg_write, cfg_index, cfg_data (no read-back)
//
// A poll is taken into an input register, then processed combinationally into
// the result register, so a poll can be accepted every cycle while the status
// is not stalled; its status comes from the result register. The limit is one
// state update per cycle in the mode and entry logic. Reset is synchronous and
// returns the block to disarmed with the configuration defaults. A stalled status holds
// the pipeline; the input register keeps taking polls while it is empty.
module keypad_alarm_controller #(
  parameter int MAX_CODE_DIGITS = 8,
  parameter int TIMER_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst,
  kac_poll_if.sink            poll,
  kac_status_if.source        status,
  input  logic                cfg_write,
  input  kac_pkg::reg_index_t cfg_index,
  input  logic [31:0]         cfg_data
);
  import kac_pkg::*;

  localparam int CNT_W = $clog2(MAX_CODE_DIGITS + 1);

  logic [31:0] passcode_digits;
  logic [3:0]  passcode_length;
  logic [15:0] arming_ticks;
  logic [15:0] blink_ticks;

  logic        in_full;
  logic        in_key_valid;
  key_code_t   in_key_code;
  logic        in_sound;
  logic        in_tick;

  logic        out_full;
  logic        advance;

  check_info_t      check;
  logic [CNT_W-1:0] count_next;
  mode_t            mode_next;
  led_t             leds_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      passcode_digits <= PASSCODE_DIGITS_RESET;
      passcode_length <= PASSCODE_LENGTH_RESET;
      arming_ticks    <= ARMING_TICKS_RESET;
      blink_ticks     <= BLINK_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PASSCODE_DIGITS: passcode_digits <= cfg_data;
        REG_PASSCODE_LENGTH: passcode_length <= cfg_data[3:0];
        REG_ARMING_TICKS:    arming_ticks    <= cfg_data[15:0];
        REG_BLINK_TICKS:     blink_ticks     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_full && (!out_full || status.ready);
  assign poll.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (poll.ready) begin
      in_full <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_key_valid <= poll.key_valid;
      in_key_code  <= poll.key_code;
      in_sound     <= poll.sound;
      in_tick      <= poll.tick;
    end
  end

  kac_entry #(
    .MAX_CODE_DIGITS(MAX_CODE_DIGITS),
    .CNT_W          (CNT_W)
  ) u_entry (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .key_valid      (in_key_valid),
    .key_code       (in_key_code),
    .passcode_digits(passcode_digits),
    .passcode_length(passcode_length),
    .check          (check),
    .count_next     (count_next)
  );

  kac_ctrl #(
    .TIMER_BITS(TIMER_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .check       (check),
    .sound       (in_sound),
    .tick        (in_tick),
    .arming_ticks(arming_ticks),
    .blink_ticks (blink_ticks),
    .mode_next   (mode_next),
    .leds_next   (leds_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (status.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status.lamp_green   <= leds_next[LED_GREEN];
      status.lamp_orange  <= leds_next[LED_ORANGE];
      status.lamp_white   <= leds_next[LED_WHITE];
      status.mode         <= mode_next;
      status.entry_length <= 4'(count_next);
      if (!check.submit) begin
        status.check_result <= CHECK_NONE;
      end else if (check.match) begin
        status.check_result <= CHECK_OK;
      end else begin
        status.check_result <= CHECK_WRONG;
      end
    end
  end

  assign status.valid = out_full;

  a_no_result_loss: assert property (@(posedge clk) disable iff (rst)
    out_full && !status.ready |=> out_full)
    else $error("pending result dropped");

  a_advance_needs_item: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_full)
    else $error("processed poll produced no result");

endmodule

### rtl/core/kac_entry.sv
module kac_entry #(
  parameter int MAX_CODE_DIGITS = 8,
  parameter int CNT_W = $clog2(MAX_CODE_DIGITS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 key_valid,
  input  kac_pkg::key_code_t   key_code,
  input  logic [31:0]          passcode_digits,
  input  logic [3:0]           passcode_length,
  output kac_pkg::check_info_t check,
  output logic [CNT_W-1:0]     count_next
);
  import kac_pkg::*;

  localparam int IDX_W = (MAX_CODE_DIGITS > 1) ? $clog2(MAX_CODE_DIGITS) : 1;
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  key_code_t        entry_buffer [MAX_CODE_DIGITS];
  logic [CNT_W-1:0] entry_count;
  logic             entry_overflow;
  logic             overflow_next;
  logic             write_en;
  logic             digits_ok;
  logic             length_ok;

  // Only entries below the passcode length are compared; a match also needs the
  // count to equal that length, so every compared entry was written since the last clear.
  always_comb begin
    logic [3:0] nib;
    digits_ok = 1'b1;
    for (int i = 0; i < MAX_CODE_DIGITS; i++) begin
      nib = passcode_length - 4'(i) - 4'd1;
      if (4'(i) < passcode_length &&
          entry_buffer[i] != passcode_digits[{nib[2:0], 2'b00} +: 4]) begin
        digits_ok = 1'b0;
      end
    end
  end

  assign length_ok = (passcode_length <= 4'd8) &&
                     (CMP_W'(passcode_length) <= CMP_W'(MAX_CODE_DIGITS)) &&
                     (CMP_W'(entry_count) == CMP_W'(passcode_length));

  assign check.submit = key_valid && (key_code == KEY_HASH);
  assign check.match  = !entry_overflow && length_ok && digits_ok;

  always_comb begin
    count_next    = entry_count;
    overflow_next = entry_overflow;
    write_en      = 1'b0;
    if (key_valid) begin
      if (key_code <= KEY_LAST_ENTRY) begin
        if (entry_count < CNT_W'(MAX_CODE_DIGITS)) begin
          write_en   = 1'b1;
          count_next = entry_count + CNT_W'(1);
        end else begin
          overflow_next = 1'b1;
        end
      end else if (key_code == KEY_STAR || key_code == KEY_HASH) begin
        count_next    = '0;
        overflow_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      entry_overflow <= 1'b0;
    end else if (advance) begin
      entry_count    <= count_next;
      entry_overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && write_en) begin
      entry_buffer[entry_count[IDX_W-1:0]] <= key_code;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_CODE_DIGITS))
    else $error("entry count beyond buffer depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    entry_overflow |-> entry_count == CNT_W'(MAX_CODE_DIGITS))
    else $error("overflow flagged with room left in the buffer");

endmodule

### rtl/core/kac_ctrl.sv
module kac_ctrl #(
  parameter int TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  kac_pkg::check_info_t check,
  input  logic                 sound,
  input  logic                 tick,
  input  logic [15:0]          arming_ticks,
  input  logic [15:0]          blink_ticks,
  output kac_pkg::mode_t       mode_next,
  output kac_pkg::led_t        leds_next
);
  import kac_pkg::*;

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  mode_t                 mode_reg;
  led_t                  led_levels;
  logic [TIMER_BITS-1:0] phase_timer;
  logic [TIMER_BITS-1:0] blink_timer;
  logic                  blink_level;
  logic [TIMER_BITS-1:0] phase_next;
  logic [TIMER_BITS-1:0] blink_next;
  logic                  level_next;

  always_comb begin
    mode_next  = mode_reg;
    leds_next  = led_levels;
    level_next = blink_level;
    phase_next = phase_timer;
    blink_next = blink_timer;

    if (tick) begin
      if (phase_timer != '1) phase_next = phase_timer + TIMER_BITS'(1);
      if (blink_timer != '1) blink_next = blink_timer + TIMER_BITS'(1);
    end

    if (check.submit && check.match) begin
      if (mode_reg == MODE_DISARMED) begin
        mode_next  = MODE_ARMING;
        phase_next = '0;
        blink_next = '0;
        level_next = 1'b0;
        leds_next  = leds_next & LEDS_KEEP_GREEN;
      end else if (mode_reg == MODE_ALARM) begin
        mode_next = MODE_DISARMED;
        leds_next = LEDS_GREEN_ONLY;
      end
    end

    // The mode update sees the mode left by the key.
    case (mode_next)
      MODE_DISARMED: begin
        leds_next = LEDS_GREEN_ONLY;
      end
      MODE_ARMING: begin
        leds_next = leds_next & LEDS_KEEP_GREEN;
        if (CMP_W'(blink_next) >= CMP_W'(blink_ticks)) begin
          blink_next           = '0;
          level_next           = !level_next;
          leds_next[LED_GREEN] = level_next;
        end
        if (CMP_W'(phase_next) >= CMP_W'(arming_ticks)) begin
          mode_next  = MODE_ARMED;
          blink_next = '0;
          level_next = 1'b0;
        end
      end
      MODE_ARMED: begin
        leds_next = LEDS_ORANGE_ONLY;
        if (sound) begin
          mode_next  = MODE_ALARM;
          blink_next = '0;
          level_next = 1'b0;
        end
      end
      default: begin
        leds_next = leds_next & LEDS_KEEP_WHITE;
        if (CMP_W'(blink_next) >= CMP_W'(blink_ticks)) begin
          blink_next           = '0;
          level_next           = !level_next;
          leds_next[LED_WHITE] = level_next;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_DISARMED;
      led_levels  <= LEDS_GREEN_ONLY;
      phase_timer <= '0;
      blink_timer <= '0;
      blink_level <= 1'b0;
    end else if (advance) begin
      mode_reg    <= mode_next;
      led_levels  <= leds_next;
      phase_timer <= phase_next;
      blink_timer <= blink_next;
      blink_level <= level_next;
    end
  end

  a_one_led: assert property (@(posedge clk) disable iff (rst)
    $onehot0(led_levels))
    else $error("more than one LED driven");

  a_arming_leds: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_ARMING |-> !led_levels[LED_ORANGE] && !led_levels[LED_WHITE])
    else $error("orange or white lit while arming");

  // With a zero arming count a correct submit goes from disarmed straight to armed.
  a_armed_entry: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_ARMED && $past(mode_reg) != MODE_ARMED)
      |-> $past(mode_reg) != MODE_ALARM)
    else $error("armed mode entered from alarm");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(mode_reg) && $stable(phase_timer))
    else $error("control state moved without an item");

endmodule
